// ----- rtl/eth_pkg.sv -----
// Package for the event time histogram: sizes, derived constants, queue entry type.
// Used by eth_front, eth_queue, eth_back and event_time_histogram.
`timescale 1ns / 1ps

package eth_pkg;

  localparam int NUM_BINS     = 1000;
  localparam int BIN_WIDTH_US = 1000;

  localparam int TIME_W  = 48;
  localparam int BIN_W   = 12;
  localparam int COUNT_W = 32;
  localparam int DIFF_W  = 32;

  localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam longint WINDOW = longint'(NUM_BINS) * longint'(BIN_WIDTH_US);

  localparam logic [DIFF_W:0] RECIP =
    (DIFF_W + 1)'((longint'(1) << DIFF_W) / longint'(BIN_WIDTH_US));

  localparam logic [DIFF_W-1:0] BIN_WIDTH_V = DIFF_W'(BIN_WIDTH_US);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_READ,
    OP_DROP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BIN_W-1:0] bin;
  } q_entry_t;

endpackage

// ----- rtl/eth_front.sv -----
// Front end: accepts request beats, tracks the origin time, classifies each request
// and finds the bin by reciprocal multiplication. Depends on eth_pkg.
`timescale 1ns / 1ps

module eth_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [47:0]               event_time,
  input  logic [11:0]               read_bin,
  input  logic                      busy,
  output logic                      push_valid,
  input  logic                      push_ready,
  output eth_pkg::q_entry_t         push_entry
);
  import eth_pkg::*;

  logic              adv;
  logic              accept;
  logic              origin_valid;
  logic [TIME_W-1:0] origin_time;
  logic [TIME_W-1:0] origin_eff;
  logic [TIME_W:0]   diff_full;
  logic              in_win;
  op_t               op_in;
  logic [BIN_W-1:0]  bin_in;

  logic              s1_valid;
  op_t               s1_op;
  logic [BIN_W-1:0]  s1_bin;
  logic [DIFF_W-1:0] s1_diff;

  logic [2*DIFF_W:0] recip_prod;
  logic              s2_valid;
  op_t               s2_op;
  logic [BIN_W-1:0]  s2_bin;
  logic [DIFF_W-1:0] s2_diff;
  logic [BIN_W-1:0]  s2_q;

  logic [DIFF_W-1:0] q_times_w;
  logic              s3_valid;
  op_t               s3_op;
  logic [BIN_W-1:0]  s3_bin;
  logic [DIFF_W-1:0] s3_diff;
  logic [BIN_W-1:0]  s3_q;
  logic [DIFF_W-1:0] s3_qw;

  logic              corr;
  logic [BIN_W-1:0]  bin_ev;

  assign adv      = !s3_valid || push_ready;
  assign in_ready = adv && !busy;
  assign accept   = in_valid && in_ready;

  assign origin_eff = origin_valid ? origin_time : event_time;
  assign diff_full  = {1'b0, event_time} - {1'b0, origin_eff};
  assign in_win     = !diff_full[TIME_W] && (diff_full[TIME_W-1:0] < TIME_W'(WINDOW));

  always_comb begin
    if (req_type) begin
      op_in  = ({1'b0, read_bin} < (BIN_W + 1)'(NUM_BINS)) ? OP_READ : OP_DROP;
      bin_in = read_bin;
    end else begin
      op_in  = in_win ? OP_COUNT : OP_DROP;
      bin_in = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_valid <= 1'b0;
    end else if (accept && !req_type && !origin_valid) begin
      origin_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !req_type && !origin_valid) begin
      origin_time <= event_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  assign recip_prod = {{(DIFF_W + 1){1'b0}}, s1_diff} * {{DIFF_W{1'b0}}, RECIP};
  assign q_times_w  = DIFF_W'(s2_q) * BIN_WIDTH_V;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op   <= op_in;
      s1_bin  <= bin_in;
      s1_diff <= diff_full[DIFF_W-1:0];
      s2_op   <= s1_op;
      s2_bin  <= s1_bin;
      s2_diff <= s1_diff;
      s2_q    <= recip_prod[DIFF_W +: BIN_W];
      s3_op   <= s2_op;
      s3_bin  <= s2_bin;
      s3_diff <= s2_diff;
      s3_q    <= s2_q;
      s3_qw   <= q_times_w;
    end
  end

  assign corr   = {1'b0, s3_diff} >= ({1'b0, s3_qw} + (DIFF_W + 1)'(BIN_WIDTH_US));
  assign bin_ev = s3_q + BIN_W'(corr);

  assign push_valid     = s3_valid;
  assign push_entry.op  = s3_op;
  assign push_entry.bin = (s3_op == OP_COUNT) ? bin_ev : s3_bin;

endmodule

// ----- rtl/eth_queue.sv -----
// Short FIFO of classified requests between front end and back end.
// Depends on eth_pkg.
`timescale 1ns / 1ps

module eth_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  eth_pkg::q_entry_t wr_entry,
  output logic              rd_valid,
  input  logic              rd_ready,
  output eth_pkg::q_entry_t rd_entry
);
  import eth_pkg::*;

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                wr_en;
  logic                rd_en;

  assign wr_ready = fill != (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + (QUEUE_AW + 1)'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - (QUEUE_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

// ----- rtl/eth_back.sv -----
// Back end: bin counter memory with clearing pass, read-modify-write with
// saturation, and the result register. Depends on eth_pkg.
`timescale 1ns / 1ps

module eth_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  eth_pkg::q_entry_t pop_entry,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [11:0]       bin_index,
  output logic              counted,
  output logic [31:0]       bin_count
);
  import eth_pkg::*;

  logic [COUNT_W-1:0] mem [NUM_BINS];
  logic               clearing;
  logic [BIN_AW-1:0]  clr_idx;

  logic               pop;
  logic               rd_en;
  logic [BIN_AW-1:0]  rd_addr;
  logic [COUNT_W-1:0] rd_data;

  logic               u_valid;
  op_t                u_op;
  logic [BIN_W-1:0]   u_bin;
  logic               u_adv;
  logic [COUNT_W-1:0] u_new;

  logic               we;
  logic [BIN_AW-1:0]  waddr;
  logic [COUNT_W-1:0] wdata;

  logic [BIN_W-1:0]   res_bin;
  logic               res_counted;
  logic [COUNT_W-1:0] res_count;

  assign busy      = clearing;
  assign u_adv     = u_valid && (!out_valid || out_ready);
  assign pop_ready = !clearing && (!u_valid || u_adv);
  assign pop       = pop_valid && pop_ready;
  assign rd_en     = pop && (pop_entry.op != OP_DROP);
  assign rd_addr   = pop_entry.bin[BIN_AW-1:0];
  assign u_new     = (rd_data == '1) ? rd_data : rd_data + COUNT_W'(1);

  assign we    = clearing || (u_adv && (u_op == OP_COUNT));
  assign waddr = clearing ? clr_idx : u_bin[BIN_AW-1:0];
  assign wdata = clearing ? '0 : u_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + BIN_AW'(1);
      if (clr_idx == BIN_AW'(NUM_BINS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= (we && (waddr == rd_addr)) ? wdata : mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid <= 1'b0;
    end else if (pop) begin
      u_valid <= 1'b1;
    end else if (u_adv) begin
      u_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      u_op  <= pop_entry.op;
      u_bin <= pop_entry.bin;
    end
  end

  always_comb begin
    unique case (u_op)
      OP_COUNT: begin
        res_bin     = u_bin;
        res_counted = 1'b1;
        res_count   = u_new;
      end
      OP_READ: begin
        res_bin     = u_bin;
        res_counted = 1'b0;
        res_count   = rd_data;
      end
      default: begin
        res_bin     = u_bin;
        res_counted = 1'b0;
        res_count   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (u_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (u_adv) begin
      bin_index <= res_bin;
      counted   <= res_counted;
      bin_count <= res_count;
    end
  end

`ifndef SYNTHESIS
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !u_valid && !out_valid)
    else $error("request in flight during clearing pass");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (u_adv && (u_op == OP_COUNT)) |=> (out_valid && counted && (bin_count != '0)))
    else $error("counted event reported zero count");

  a_counted_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && counted) |-> ({1'b0, bin_index} < (BIN_W + 1)'(NUM_BINS)))
    else $error("counted event outside bin range");
`endif

endmodule

// ----- rtl/event_time_histogram.sv -----
// Top level of the event time histogram: front end, request queue and back end.
// Depends on eth_pkg, eth_front, eth_queue and eth_back.
`timescale 1ns / 1ps

// Sorts timestamped events into NUM_BINS bins of BIN_WIDTH_US microseconds each and
// answers reads of a single bin; every request beat yields exactly one result beat,
// in order. The first count event after reset sets the origin and lands in bin 0.
// After reset the block runs a clearing pass over the counter memory, one bin per
// cycle, with in_ready low. Afterwards it takes one request per cycle while out_ready
// stays high; the counter memory's single read-modify-write per cycle, with write
// data bypassed to the next read, sets that rate. A request that is taken loads the
// first of three front stages for the bin division by reciprocal multiplication;
// from there it passes a queue slot, then the memory read register and the update,
// and then the output register.
module event_time_histogram (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [47:0] event_time,
  input  logic [11:0] read_bin,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] bin_index,
  output logic        counted,
  output logic [31:0] bin_count
);
  import eth_pkg::*;

  logic     busy;
  logic     push_valid;
  logic     push_ready;
  q_entry_t push_entry;
  logic     pop_valid;
  logic     pop_ready;
  q_entry_t pop_entry;

  eth_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .event_time (event_time),
    .read_bin   (read_bin),
    .busy       (busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  eth_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_entry (push_entry),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_entry (pop_entry)
  );

  eth_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin_index (bin_index),
    .counted   (counted),
    .bin_count (bin_count)
  );

endmodule
